### rtl/hsvrgb_pkg.sv
`timescale 1ns / 1ps

package hsvrgb_pkg;

    // Pipeline depth from input register to output register
    localparam int NUM_STAGES = 7;

    localparam int HUE_W    = 16;
    localparam int CHAN_W   = 8;
    localparam int DEG_W    = 9;
    localparam int HUE_X_W  = HUE_W + 1;

    // hue + 32768 + 352 has the same residue modulo 360 as hue, and is never negative
    localparam logic [HUE_X_W-1:0] HUE_OFFSET      = 17'd352;
    localparam logic [13:0]        HUE_RECIP       = 14'd11650;  // floor(2^22 / 360)
    localparam int                 HUE_RECIP_SHIFT = 22;
    localparam logic [DEG_W:0]     FULL_TURN       = 10'd360;
    localparam logic [DEG_W-1:0]   SECTOR_DEG      = 9'd60;
    localparam logic [CHAN_W-1:0]  FULL_SCALE      = 8'd255;

    typedef enum logic [2:0] {
        SEC_R_Y,
        SEC_Y_G,
        SEC_G_C,
        SEC_C_B,
        SEC_B_M,
        SEC_M_R
    } sector_t;

    typedef struct packed {
        logic adv1;
        logic adv2;
    } hr_ctrl_t;

    // Truncating divide by 255 for x <= 65025: reciprocal estimate, then one correction
    function automatic logic [CHAN_W-1:0] div255(input logic [15:0] x);
        logic [24:0]       prod;
        logic [CHAN_W-1:0] est;
        logic [16:0]       rem;
        prod = {9'd0, x} * 25'd257;
        est  = prod[23:16];
        rem  = {1'b0, x} - ({9'd0, est} * 17'd255);
        if (rem >= 17'd255)
        begin
            div255 = est + 8'd1;
        end
        else
        begin
            div255 = est;
        end
    endfunction

endpackage

### rtl/hsvrgb_hue_reduce.sv
`timescale 1ns / 1ps

// Two-stage hue reduction into 0..359 (floor modulo 360)
module hsvrgb_hue_reduce
    import hsvrgb_pkg::*;
(
    input  logic                    clk,
    input  hr_ctrl_t                ctrl,
    input  logic signed [HUE_W-1:0] hue,
    output logic [DEG_W-1:0]        deg
);

    logic [HUE_X_W-1:0] x_reg, x_next;
    logic [7:0]         q_reg, q_next;
    logic [DEG_W-1:0]   deg_reg, deg_next;
    logic [30:0]        prod;
    logic [DEG_W:0]     rem;

    // Stage 1: bias to unsigned and estimate the quotient
    always_comb
    begin
        x_next = {1'b0, hue ^ 16'h8000} + HUE_OFFSET;
        prod   = {14'd0, x_next} * {17'd0, HUE_RECIP};
        q_next = prod[HUE_RECIP_SHIFT+7:HUE_RECIP_SHIFT];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv1)
        begin
            x_reg <= x_next;
            q_reg <= q_next;
        end
    end

    // Stage 2: remainder, correct an estimate that came out one low
    always_comb
    begin
        rem = 10'(x_reg - ({9'd0, q_reg} * 17'd360));
        if (rem >= FULL_TURN)
        begin
            rem = rem - FULL_TURN;
        end
        deg_next = rem[DEG_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv2)
        begin
            deg_reg <= deg_next;
        end
    end

    assign deg = deg_reg;

endmodule

### rtl/hsv_to_rgb_integer_core.sv
`timescale 1ns / 1ps

// HSV to RGB converter, 8-bit integer arithmetic, no state between words.
//
// Input channel s_*: one colour per word. s_tdata bits [15:0] signed hue in
// degrees (any value, reduced modulo 360), [23:16] saturation, [31:24] value.
// Output channel m_*: one result word per input word, in order. m_tdata bits
// [7:0] red, [15:8] green, [23:16] blue.
//
// A word accepted on s_* is offered on m_* after passing through seven
// register stages: two for the hue modulo, one for sector split, then
// multiply, divide by 255, multiply, divide by 255 and channel select.
// Throughput is one word per cycle while m_tready is held high; each stage
// holds one word and the multipliers are not shared.
//
// Each stage carries a valid bit and advances when it is empty or the stage
// after it advances, so a stall on m_tready holds the full stages and lets
// the empty ones keep filling: s_tready drops only when every stage holds a
// word. Reset clears the valid bits, dropping any words in flight; the
// block takes input on the first cycle after reset.
module hsv_to_rgb_integer_core
    import hsvrgb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // hue[15:0], saturation[23:16], brightness_value[31:24]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // red[7:0], green[15:8], blue[23:16]
);

    logic [NUM_STAGES:1] vld_reg, vld_next;
    logic [NUM_STAGES:1] adv;

    // Advance chain: a stage moves when empty or when its successor moves
    always_comb
    begin
        adv[NUM_STAGES] = !vld_reg[NUM_STAGES] || m_tready;
        for (int i = NUM_STAGES - 1; i >= 1; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (adv[1])
        begin
            vld_next[1] = s_tvalid;
        end
        for (int i = 2; i <= NUM_STAGES; i++)
        begin
            if (adv[i])
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = adv[1];
    assign m_tvalid = vld_reg[NUM_STAGES];

    // Stages 1-2: hue to degrees 0..359
    hr_ctrl_t         hr_ctrl;
    logic [DEG_W-1:0] deg;

    assign hr_ctrl.adv1 = adv[1];
    assign hr_ctrl.adv2 = adv[2];

    hsvrgb_hue_reduce u_hue (
        .clk  (clk),
        .ctrl (hr_ctrl),
        .hue  (s_tdata[15:0]),
        .deg  (deg)
    );

    // Carry saturation and value alongside the hue stages
    logic [CHAN_W-1:0] sat1_reg, val1_reg, sat2_reg, val2_reg;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            sat1_reg <= s_tdata[23:16];
            val1_reg <= s_tdata[31:24];
        end
        if (adv[2])
        begin
            sat2_reg <= sat1_reg;
            val2_reg <= val1_reg;
        end
    end

    // Stage 3: sector, remainder scaled to 0..250 (x * 255 / 60 = x * 17 / 4), p product
    sector_t           sector3_reg, sector3_next;
    logic [CHAN_W-1:0] frac3_reg, frac3_next;
    logic [15:0]       pv3_reg, pv3_next;
    logic [CHAN_W-1:0] sat3_reg, val3_reg;
    logic [DEG_W-1:0]  base;
    logic [DEG_W-1:0]  rem;
    logic [9:0]        rem17;

    always_comb
    begin
        if (deg < SECTOR_DEG)
        begin
            sector3_next = SEC_R_Y;
            base         = 9'd0;
        end
        else if (deg < 9'd120)
        begin
            sector3_next = SEC_Y_G;
            base         = SECTOR_DEG;
        end
        else if (deg < 9'd180)
        begin
            sector3_next = SEC_G_C;
            base         = 9'd120;
        end
        else if (deg < 9'd240)
        begin
            sector3_next = SEC_C_B;
            base         = 9'd180;
        end
        else if (deg < 9'd300)
        begin
            sector3_next = SEC_B_M;
            base         = 9'd240;
        end
        else
        begin
            sector3_next = SEC_M_R;
            base         = 9'd300;
        end
        rem        = deg - base;
        rem17      = {rem[5:0], 4'b0000} + {4'b0000, rem[5:0]};
        frac3_next = rem17[9:2];
        pv3_next   = {8'd0, val2_reg} * {8'd0, FULL_SCALE - sat2_reg};
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            sector3_reg <= sector3_next;
            frac3_reg   <= frac3_next;
            pv3_reg     <= pv3_next;
            sat3_reg    <= sat2_reg;
            val3_reg    <= val2_reg;
        end
    end

    // Stage 4: saturation products for q and t, finish p
    logic [15:0]       sf4_reg, sfc4_reg;
    logic [CHAN_W-1:0] p4_reg, val4_reg;
    sector_t           sector4_reg;

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            sf4_reg     <= {8'd0, sat3_reg} * {8'd0, frac3_reg};
            sfc4_reg    <= {8'd0, sat3_reg} * {8'd0, FULL_SCALE - frac3_reg};
            p4_reg      <= div255(pv3_reg);
            val4_reg    <= val3_reg;
            sector4_reg <= sector3_reg;
        end
    end

    // Stage 5: complement the scaled saturation terms
    logic [CHAN_W-1:0] a5_reg, b5_reg, p5_reg, val5_reg;
    sector_t           sector5_reg;

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            a5_reg      <= FULL_SCALE - div255(sf4_reg);
            b5_reg      <= FULL_SCALE - div255(sfc4_reg);
            p5_reg      <= p4_reg;
            val5_reg    <= val4_reg;
            sector5_reg <= sector4_reg;
        end
    end

    // Stage 6: scale by value
    logic [15:0]       qv6_reg, tv6_reg;
    logic [CHAN_W-1:0] p6_reg, val6_reg;
    sector_t           sector6_reg;

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            qv6_reg     <= {8'd0, val5_reg} * {8'd0, a5_reg};
            tv6_reg     <= {8'd0, val5_reg} * {8'd0, b5_reg};
            p6_reg      <= p5_reg;
            val6_reg    <= val5_reg;
            sector6_reg <= sector5_reg;
        end
    end

    // Stage 7: finish q and t, route terms to channels.
    // Zero saturation needs no special path: p, q and t all reduce to value.
    logic [CHAN_W-1:0] q7, t7;
    logic [CHAN_W-1:0] red_next, green_next, blue_next;
    logic [CHAN_W-1:0] red_reg, green_reg, blue_reg;

    always_comb
    begin
        q7 = div255(qv6_reg);
        t7 = div255(tv6_reg);
        case (sector6_reg)
            SEC_R_Y:
            begin
                red_next = val6_reg; green_next = t7;       blue_next = p6_reg;
            end
            SEC_Y_G:
            begin
                red_next = q7;       green_next = val6_reg; blue_next = p6_reg;
            end
            SEC_G_C:
            begin
                red_next = p6_reg;   green_next = val6_reg; blue_next = t7;
            end
            SEC_C_B:
            begin
                red_next = p6_reg;   green_next = q7;       blue_next = val6_reg;
            end
            SEC_B_M:
            begin
                red_next = t7;       green_next = p6_reg;   blue_next = val6_reg;
            end
            default:
            begin
                red_next = val6_reg; green_next = p6_reg;   blue_next = q7;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign m_tdata = {blue_reg, green_reg, red_reg};

endmodule

### rtl/hsvrgb_checker.sv
`timescale 1ns / 1ps

module hsvrgb_checker
    import hsvrgb_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // Words accepted but not yet delivered
    logic [3:0] inflight_reg, inflight_next;

    always_comb
    begin
        inflight_next = inflight_reg;
        if ((s_tvalid && s_tready) && !(m_tvalid && m_tready))
        begin
            inflight_next = inflight_reg + 4'd1;
        end
        else if (!(s_tvalid && s_tready) && (m_tvalid && m_tready))
        begin
            inflight_next = inflight_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output word changed or dropped");

    // An empty output stage means the pipeline can take input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output stage empty");

    // No result without a word in flight
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> inflight_reg != 4'd0)
        else $error("result word without accepted input");

    // Occupancy never exceeds the pipeline depth
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 4'(NUM_STAGES))
        else $error("more words in flight than pipeline stages");

endmodule

bind hsv_to_rgb_integer_core hsvrgb_checker u_hsvrgb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
